### rtl/core/pcl_pkg.sv
// Shared types and constants for the positional character list.
// No dependencies; imported by pcl_ctrl, pcl_dpath and positional_char_list_core.
package pcl_pkg;

  localparam logic [7:0] SENTINEL = 8'h30;

  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_DELETE = 3'd1,
    KIND_LOCATE = 3'd2,
    KIND_NEXT   = 3'd3,
    KIND_PREV   = 3'd4,
    KIND_PURGE  = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE,
    S_INS_RD, S_INS_MV, S_INS_WR,
    S_DEL_RD, S_DEL_MV,
    S_LOC_RD, S_LOC_CMP,
    S_RD_ONE, S_RD_VAL,
    S_PUR_RD, S_PUR_LAT, S_PUR_KRD, S_PUR_KCMP, S_PUR_KEEP, S_PUR_NEXT,
    S_RESULT
  } state_e;

  typedef enum logic [2:0] {
    PTR_HOLD, PTR_COUNT, PTR_POS, PTR_ZERO, PTR_INC, PTR_DEC
  } ptr_op_e;

  typedef enum logic [1:0] {
    RD_PTR, RD_PTR_M1, RD_K, RD_POS
  } rd_src_e;

  typedef enum logic [2:0] {
    WR_NONE, WR_SHIFT_UP, WR_SHIFT_DN, WR_ELEM, WR_KEEP
  } wr_src_e;

  typedef enum logic [1:0] {
    CNT_HOLD, CNT_INC, CNT_DEC, CNT_KEPT
  } cnt_op_e;

  typedef enum logic [2:0] {
    RES_NONE, RES_CHECK, RES_NOTFOUND, RES_FOUND, RES_VALUE
  } res_op_e;

  typedef struct packed {
    logic    load;
    ptr_op_e ptr_op;
    rd_src_e rd_src;
    wr_src_e wr_src;
    cnt_op_e cnt_op;
    logic    k_zero;
    logic    k_inc;
    logic    kept_zero;
    logic    kept_inc;
    logic    v_load;
    res_op_e res_op;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       chk_ok;
    logic       rd_eq_elem;
    logic       rd_eq_v;
    logic       ptr_eq_pos;
    logic       ptr_p1_eq_count;
    logic       k_p1_eq_kept;
    logic       kept_zero;
    logic       pos_eq_count;
    logic       pos_eq_cnt_p1;
  } stat_t;

endpackage

### rtl/core/pcl_ctrl.sv
// Sequencer for the positional character list: one request at a time.
// Depends on pcl_pkg; drives pcl_dpath through cmd_t, reads stat_t.
module pcl_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  pcl_pkg::stat_t stat_i,
  output pcl_pkg::cmd_t  cmd_o
);
  import pcl_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (!stat_i.chk_ok) begin
          state_d = S_RESULT;
        end else begin
          case (stat_i.kind)
            KIND_INSERT: state_d = stat_i.pos_eq_cnt_p1 ? S_INS_WR : S_INS_RD;
            KIND_DELETE: state_d = stat_i.pos_eq_count ? S_RESULT : S_DEL_RD;
            KIND_LOCATE: state_d = S_LOC_RD;
            KIND_NEXT, KIND_PREV: state_d = S_RD_ONE;
            KIND_PURGE:  state_d = S_PUR_RD;
            default:     state_d = S_RESULT;
          endcase
        end
      end
      S_INS_RD:  state_d = S_INS_MV;
      S_INS_MV:  state_d = stat_i.ptr_eq_pos ? S_INS_WR : S_INS_RD;
      S_INS_WR:  state_d = S_RESULT;
      S_DEL_RD:  state_d = S_DEL_MV;
      S_DEL_MV:  state_d = stat_i.ptr_p1_eq_count ? S_RESULT : S_DEL_RD;
      S_LOC_RD:  state_d = S_LOC_CMP;
      S_LOC_CMP: begin
        if (stat_i.rd_eq_elem || stat_i.ptr_p1_eq_count) state_d = S_RESULT;
        else state_d = S_LOC_RD;
      end
      S_RD_ONE:  state_d = S_RD_VAL;
      S_RD_VAL:  state_d = S_RESULT;
      S_PUR_RD:  state_d = S_PUR_LAT;
      S_PUR_LAT: state_d = stat_i.kept_zero ? S_PUR_KEEP : S_PUR_KRD;
      S_PUR_KRD: state_d = S_PUR_KCMP;
      S_PUR_KCMP: begin
        if (stat_i.rd_eq_v) state_d = S_PUR_NEXT;
        else if (stat_i.k_p1_eq_kept) state_d = S_PUR_KEEP;
        else state_d = S_PUR_KRD;
      end
      S_PUR_KEEP: state_d = S_PUR_NEXT;
      S_PUR_NEXT: state_d = stat_i.ptr_p1_eq_count ? S_RESULT : S_PUR_RD;
      S_RESULT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.ptr_op = PTR_HOLD;
    cmd_o.rd_src = RD_PTR;
    cmd_o.wr_src = WR_NONE;
    cmd_o.cnt_op = CNT_HOLD;
    cmd_o.res_op = RES_NONE;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_DECODE: begin
        if (!stat_i.chk_ok) begin
          cmd_o.res_op = RES_CHECK;
        end else begin
          case (stat_i.kind)
            KIND_INSERT: cmd_o.ptr_op = PTR_COUNT;
            KIND_DELETE: begin
              cmd_o.ptr_op = PTR_POS;
              if (stat_i.pos_eq_count) begin
                cmd_o.cnt_op = CNT_DEC;
                cmd_o.res_op = RES_CHECK;
              end
            end
            KIND_LOCATE: cmd_o.ptr_op = PTR_ZERO;
            KIND_NEXT, KIND_PREV: cmd_o.ptr_op = PTR_HOLD;
            KIND_PURGE: begin
              cmd_o.ptr_op    = PTR_ZERO;
              cmd_o.kept_zero = 1'b1;
            end
            default: cmd_o.res_op = RES_CHECK;
          endcase
        end
      end
      S_INS_RD: cmd_o.rd_src = RD_PTR_M1;
      S_INS_MV: begin
        cmd_o.wr_src = WR_SHIFT_UP;
        cmd_o.ptr_op = PTR_DEC;
      end
      S_INS_WR: begin
        cmd_o.wr_src = WR_ELEM;
        cmd_o.cnt_op = CNT_INC;
        cmd_o.res_op = RES_CHECK;
      end
      S_DEL_RD: cmd_o.rd_src = RD_PTR;
      S_DEL_MV: begin
        cmd_o.wr_src = WR_SHIFT_DN;
        cmd_o.ptr_op = PTR_INC;
        if (stat_i.ptr_p1_eq_count) begin
          cmd_o.cnt_op = CNT_DEC;
          cmd_o.res_op = RES_CHECK;
        end
      end
      S_LOC_RD: cmd_o.rd_src = RD_PTR;
      S_LOC_CMP: begin
        if (stat_i.rd_eq_elem) cmd_o.res_op = RES_FOUND;
        else if (stat_i.ptr_p1_eq_count) cmd_o.res_op = RES_NOTFOUND;
        else cmd_o.ptr_op = PTR_INC;
      end
      S_RD_ONE: cmd_o.rd_src = RD_POS;
      S_RD_VAL: cmd_o.res_op = RES_VALUE;
      S_PUR_RD: cmd_o.rd_src = RD_PTR;
      S_PUR_LAT: begin
        cmd_o.v_load = 1'b1;
        cmd_o.k_zero = 1'b1;
      end
      S_PUR_KRD: cmd_o.rd_src = RD_K;
      S_PUR_KCMP: begin
        if (!stat_i.rd_eq_v) cmd_o.k_inc = 1'b1;
      end
      S_PUR_KEEP: begin
        cmd_o.wr_src   = WR_KEEP;
        cmd_o.kept_inc = 1'b1;
      end
      S_PUR_NEXT: begin
        if (stat_i.ptr_p1_eq_count) begin
          cmd_o.cnt_op = CNT_KEPT;
          cmd_o.res_op = RES_CHECK;
        end else begin
          cmd_o.ptr_op = PTR_INC;
        end
      end
      S_RESULT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

### rtl/core/pcl_dpath.sv
// Datapath: entry memory, count, scan pointers, request and result registers.
// Depends on pcl_pkg; commanded by pcl_ctrl.
module pcl_dpath #(
  parameter int CAPACITY = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pcl_pkg::cmd_t  cmd_i,
  output pcl_pkg::stat_t stat_o,
  input  logic [2:0]     kind_i,
  input  logic [6:0]     position_i,
  input  logic [7:0]     element_i,
  output logic [2:0]     status_o,
  output logic [7:0]     value_o,
  output logic [6:0]     found_index_o,
  output logic [6:0]     length_o
);
  import pcl_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int XW = CW + 8;

  logic [7:0]    mem [CAPACITY];
  logic [7:0]    rd_q;
  logic [2:0]    kind_q;
  logic [6:0]    pos_q;
  logic [7:0]    elem_q, v_q;
  logic [CW-1:0] count_q, count_d, ptr_q, ptr_d, k_q, kept_q;
  logic [2:0]    status_q;
  logic [7:0]    value_q;
  logic [6:0]    found_q;

  logic [XW-1:0] pos_x, cnt_x, ptr_x;
  logic          chk_ok;
  status_e       chk_status;
  logic          we;
  logic [AW-1:0] wa, ra;
  logic [7:0]    wd;

  assign pos_x = XW'(pos_q);
  assign cnt_x = XW'(count_q);
  assign ptr_x = XW'(ptr_q);

  always_comb begin
    chk_status = ST_OK;
    case (kind_q)
      KIND_INSERT: begin
        if (cnt_x == XW'(CAPACITY)) chk_status = ST_FULL;
        else if (pos_x == '0 || pos_x > cnt_x + XW'(1)) chk_status = ST_BADPOS;
      end
      KIND_DELETE: begin
        if (count_q == '0) chk_status = ST_EMPTY;
        else if (pos_x == '0 || pos_x > cnt_x) chk_status = ST_BADPOS;
      end
      KIND_LOCATE, KIND_PURGE: begin
        if (count_q == '0) chk_status = ST_EMPTY;
      end
      KIND_NEXT: begin
        if (count_q == '0) chk_status = ST_EMPTY;
        else if (pos_x == '0 || pos_x >= cnt_x) chk_status = ST_BADPOS;
      end
      KIND_PREV: begin
        if (count_q == '0) chk_status = ST_EMPTY;
        else if (pos_x < XW'(2) || pos_x > cnt_x) chk_status = ST_BADPOS;
      end
      default: chk_status = ST_OK;
    endcase
  end
  assign chk_ok = (chk_status == ST_OK);

  always_comb begin
    stat_o.kind            = kind_q;
    stat_o.chk_ok          = chk_ok;
    stat_o.rd_eq_elem      = (rd_q == elem_q);
    stat_o.rd_eq_v         = (rd_q == v_q);
    stat_o.ptr_eq_pos      = (ptr_x == pos_x);
    stat_o.ptr_p1_eq_count = (ptr_x + XW'(1) == cnt_x);
    stat_o.k_p1_eq_kept    = (k_q + CW'(1) == kept_q);
    stat_o.kept_zero       = (kept_q == '0);
    stat_o.pos_eq_count    = (pos_x == cnt_x);
    stat_o.pos_eq_cnt_p1   = (pos_x == cnt_x + XW'(1));
  end

  always_comb begin
    case (cmd_i.rd_src)
      RD_PTR:    ra = AW'(ptr_q);
      RD_PTR_M1: ra = AW'(ptr_q - CW'(1));
      RD_K:      ra = AW'(k_q);
      RD_POS:    ra = (kind_q == KIND_NEXT) ? AW'(pos_x) : AW'(pos_x - XW'(2));
      default:   ra = '0;
    endcase
  end

  always_comb begin
    we = 1'b1;
    wa = '0;
    wd = rd_q;
    case (cmd_i.wr_src)
      WR_SHIFT_UP: wa = AW'(ptr_q);
      WR_SHIFT_DN: wa = AW'(ptr_q - CW'(1));
      WR_ELEM: begin
        wa = AW'(pos_x - XW'(1));
        wd = elem_q;
      end
      WR_KEEP: begin
        wa = AW'(kept_q);
        wd = v_q;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  always_comb begin
    case (cmd_i.ptr_op)
      PTR_COUNT: ptr_d = count_q;
      PTR_POS:   ptr_d = CW'(pos_x);
      PTR_ZERO:  ptr_d = '0;
      PTR_INC:   ptr_d = ptr_q + CW'(1);
      PTR_DEC:   ptr_d = ptr_q - CW'(1);
      default:   ptr_d = ptr_q;
    endcase
    case (cmd_i.cnt_op)
      CNT_INC:  count_d = count_q + CW'(1);
      CNT_DEC:  count_d = count_q - CW'(1);
      CNT_KEPT: count_d = kept_q;
      default:  count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.load) begin
      kind_q <= kind_i;
      pos_q  <= position_i;
      elem_q <= element_i;
    end
    if (cmd_i.v_load) v_q <= rd_q;
    if (cmd_i.k_zero) k_q <= '0;
    else if (cmd_i.k_inc) k_q <= k_q + CW'(1);
    if (cmd_i.kept_zero) kept_q <= '0;
    else if (cmd_i.kept_inc) kept_q <= kept_q + CW'(1);
    case (cmd_i.res_op)
      RES_CHECK: begin
        status_q <= chk_status;
        value_q  <= SENTINEL;
        found_q  <= '0;
      end
      RES_NOTFOUND: begin
        status_q <= ST_NOTFOUND;
        value_q  <= SENTINEL;
        found_q  <= '0;
      end
      RES_FOUND: begin
        status_q <= ST_OK;
        value_q  <= SENTINEL;
        found_q  <= 7'(ptr_x + XW'(1));
      end
      RES_VALUE: begin
        status_q <= ST_OK;
        value_q  <= rd_q;
        found_q  <= '0;
      end
      default: ;
    endcase
  end

  assign status_o      = status_q;
  assign value_o       = value_q;
  assign found_index_o = found_q;
  assign length_o      = 7'(count_q);

endmodule

### rtl/core/positional_char_list_core.sv
// Top level of the positional character list: ordered byte list with
// insert, delete, locate, next, previous and duplicate purge.
// Depends on pcl_pkg, pcl_ctrl and pcl_dpath.
//
// Requests arrive on the s_axis channel, one beat per request; each gives
// exactly one result beat on m_axis. One request is in work at a time:
// s_axis_tready is high only while the block is idle.
// Work per request (n = length, k = kept values): next and previous read
//   one entry; errors and unused kinds go straight to the result;
//   insert at p moves the entries from n down to p up by one; delete at p
//   moves the entries above p down by one; locate scans from the first entry
//   to a match or to n; purge checks each entry against up to k kept values,
//   all through the single memory read port that both the outer and the inner scan share.
// A result waits in the output register while m_axis_tready is low; no
// new request is taken until it is delivered and the block is back in idle.
// Reset empties the list at once; the entry memory needs no clearing.
module positional_char_list_core #(
  parameter int CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // position[6:0], element[14:7]
  input  logic [2:0]  s_axis_tuser,  // kind[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // status[2:0], value[10:3], found_index[17:11],
                                     // length[24:18]
);
  import pcl_pkg::*;

  cmd_t       cmd;
  stat_t      stat;
  logic [2:0] status;
  logic [7:0] value;
  logic [6:0] found_index;
  logic [6:0] length;

  pcl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pcl_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .kind_i        (s_axis_tuser),
    .position_i    (s_axis_tdata[6:0]),
    .element_i     (s_axis_tdata[14:7]),
    .status_o      (status),
    .value_o       (value),
    .found_index_o (found_index),
    .length_o      (length)
  );

  assign m_axis_tdata = {7'd0, length, found_index, value, status};

endmodule
